/* src/assert_macros.svh */
// assertion helpers used by hybrid_branch_predictor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/hbp_pkg.sv */
// ----------------------------------------------------------------------------
// hbp_pkg
// types, constants and helpers of the hybrid branch predictor
// ----------------------------------------------------------------------------
`default_nettype none

package hbp_pkg;

    // resolved branch transaction
    typedef struct packed {
        logic [31:0] branch_pc;
        logic        taken;
    } branch_t;

    // prediction result transaction
    typedef struct packed {
        logic predicted_taken;
        logic mispredicted;
        logic chose_gshare;
    } result_t;

    typedef logic [2:0] ctr3_t;
    typedef logic [1:0] ctr2_t;

    localparam ctr3_t CTR3_MAX       = 3'd7;
    localparam ctr3_t CTR3_TAKEN_MIN = 3'd4;
    localparam ctr3_t CTR3_RESET     = 3'd4;
    localparam ctr2_t CHOOSER_MAX    = 2'd3;
    localparam ctr2_t CHOOSER_G_MIN  = 2'd2;
    localparam ctr2_t CHOOSER_RESET  = 2'd1;

    localparam int    WORD_PC_BITS   = 30;
    localparam int    OQ_DEPTH       = 3;

    // decisions and new table values for one branch
    typedef struct packed {
        logic  predicted_taken;
        logic  mispredicted;
        logic  chose_gshare;
        logic  bimodal_we;
        logic  gshare_we;
        ctr3_t bimodal_ctr;
        ctr3_t gshare_ctr;
        ctr2_t chooser_ctr;
    } upd_t;

    function automatic ctr3_t train3(input ctr3_t c, input logic up);
        ctr3_t r;
        r = c;
        if (up)
        begin
            if (c != CTR3_MAX)
                r = c + 3'd1;
        end
        else
        begin
            if (c != 3'd0)
                r = c - 3'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/hbp_ram.sv */
// ----------------------------------------------------------------------------
// hbp_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* src/hbp_update.sv */
// ----------------------------------------------------------------------------
// hbp_update
// forms both predictions, picks one and computes the trained counters
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_update (
    input  wire logic           taken,
    input  wire hbp_pkg::ctr3_t bimodal_ctr,
    input  wire hbp_pkg::ctr3_t gshare_ctr,
    input  wire hbp_pkg::ctr2_t chooser_ctr,
    output hbp_pkg::upd_t       upd
);

    logic bpred;
    logic gpred;
    logic use_g;
    logic pred;

    always_comb
    begin
        bpred = (bimodal_ctr >= hbp_pkg::CTR3_TAKEN_MIN);
        gpred = (gshare_ctr >= hbp_pkg::CTR3_TAKEN_MIN);
        use_g = (chooser_ctr >= hbp_pkg::CHOOSER_G_MIN);
        pred  = use_g ? gpred : bpred;

        upd.predicted_taken = pred;
        upd.mispredicted    = pred ^ taken;
        upd.chose_gshare    = use_g;
        upd.bimodal_we      = !use_g;
        upd.gshare_we       = use_g;
        upd.bimodal_ctr     = hbp_pkg::train3(bimodal_ctr, taken);
        upd.gshare_ctr      = hbp_pkg::train3(gshare_ctr, taken);

        // chooser leans toward the predictor that alone was right
        upd.chooser_ctr = chooser_ctr;
        if (bpred == taken && gpred != taken)
        begin
            if (chooser_ctr != 2'd0)
                upd.chooser_ctr = chooser_ctr - 2'd1;
        end
        else if (bpred != taken && gpred == taken)
        begin
            if (chooser_ctr != hbp_pkg::CHOOSER_MAX)
                upd.chooser_ctr = chooser_ctr + 2'd1;
        end
    end

endmodule

`default_nettype wire

/* src/hbp_out_queue.sv */
// ----------------------------------------------------------------------------
// hbp_out_queue
// small result queue between the update stage and the result port
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_out_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire hbp_pkg::result_t push_data,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output hbp_pkg::result_t      result,
    output logic [1:0]            count
);

    hbp_pkg::result_t entry_reg [hbp_pkg::OQ_DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != 2'd0);
    assign result       = entry_reg[rd_ptr_reg];
    assign count        = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == 2'(hbp_pkg::OQ_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == 2'(hbp_pkg::OQ_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* src/hybrid_branch_predictor.sv */
// ----------------------------------------------------------------------------
// hybrid_branch_predictor
// tournament predictor: bimodal and gshare tables with a per-pc chooser
// ----------------------------------------------------------------------------
// a result is registered in the update stage, then in the result queue, before
// it is offered; throughput: one branch per cycle while branch_ready is high
// (low in the clearing pass and when the queue and update stage fill), set by
// the single read-modify-write of each table ram (registered read, write-back
// from the update stage with a bypass). reset: a clearing pass writes the
// initial counters into all three rams; no branch is taken during it
`default_nettype none
`include "assert_macros.svh"

module hybrid_branch_predictor #(
    parameter int CHOOSER_INDEX_BITS = 10,
    parameter int BIMODAL_INDEX_BITS = 12,
    parameter int GSHARE_INDEX_BITS  = 12,
    parameter int HISTORY_BITS       = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             branch_valid,
    output logic                  branch_ready,
    input  wire hbp_pkg::branch_t branch,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output hbp_pkg::result_t      result
);

    localparam int CI = CHOOSER_INDEX_BITS;
    localparam int BI = BIMODAL_INDEX_BITS;
    localparam int GI = GSHARE_INDEX_BITS;
    localparam int H  = HISTORY_BITS;
    localparam int MB_CB = (CI > BI) ? CI : BI;
    localparam int MB    = (MB_CB > GI) ? MB_CB : GI;

    // clearing pass
    logic          clearing_reg;
    logic [MB-1:0] clr_cnt_reg;

    // global history
    logic [H-1:0] history_reg;
    logic [H-1:0] history_next;

    // index forming
    logic [hbp_pkg::WORD_PC_BITS-1:0] wpc;
    logic [hbp_pkg::WORD_PC_BITS-1:0] hist_w;
    logic [hbp_pkg::WORD_PC_BITS-1:0] gx;
    logic [CI-1:0] ci_in;
    logic [BI-1:0] bi_in;
    logic [GI-1:0] gi_in;
    logic          accept;

    // update stage
    logic          s1_valid_reg;
    logic          s1_taken_reg;
    logic [CI-1:0] s1_ci_reg;
    logic [BI-1:0] s1_bi_reg;
    logic [GI-1:0] s1_gi_reg;

    // ram ports
    logic           c_we;
    logic [CI-1:0]  c_waddr;
    hbp_pkg::ctr2_t c_wdata;
    hbp_pkg::ctr2_t c_rdata;
    logic           b_we;
    logic [BI-1:0]  b_waddr;
    hbp_pkg::ctr3_t b_wdata;
    hbp_pkg::ctr3_t b_rdata;
    logic           g_we;
    logic [GI-1:0]  g_waddr;
    hbp_pkg::ctr3_t g_wdata;
    hbp_pkg::ctr3_t g_rdata;

    // bypass of the write that coincided with the read
    logic           c_byp_valid_reg;
    logic [CI-1:0]  c_byp_addr_reg;
    hbp_pkg::ctr2_t c_byp_data_reg;
    logic           b_byp_valid_reg;
    logic [BI-1:0]  b_byp_addr_reg;
    hbp_pkg::ctr3_t b_byp_data_reg;
    logic           g_byp_valid_reg;
    logic [GI-1:0]  g_byp_addr_reg;
    hbp_pkg::ctr3_t g_byp_data_reg;

    hbp_pkg::ctr2_t   c_cur;
    hbp_pkg::ctr3_t   b_cur;
    hbp_pkg::ctr3_t   g_cur;
    hbp_pkg::upd_t    upd;
    hbp_pkg::result_t s1_result;
    logic [1:0]       q_count;
    logic [2:0]       occupancy;

    assign occupancy    = 3'(q_count) + 3'(s1_valid_reg);
    assign branch_ready = !clearing_reg && (occupancy <= 3'd2);
    assign accept       = branch_valid && branch_ready;

    always_comb
    begin
        wpc    = branch.branch_pc[31:2];
        hist_w = {{(hbp_pkg::WORD_PC_BITS - H){1'b0}}, history_reg};
        gx     = wpc ^ hist_w;
        ci_in  = wpc[CI-1:0];
        bi_in  = wpc[BI-1:0];
        gi_in  = gx[GI-1:0];
        // outcome enters at the top, oldest bit drops off the bottom
        history_next = (history_reg >> 1) | (H'(branch.taken) << (H - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            history_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + MB'(1);
                if (&clr_cnt_reg)
                    clearing_reg <= 1'b0;
            end
            if (accept)
                history_reg <= history_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_taken_reg <= branch.taken;
            s1_ci_reg    <= ci_in;
            s1_bi_reg    <= bi_in;
            s1_gi_reg    <= gi_in;
        end
    end

    always_comb
    begin
        c_cur = (c_byp_valid_reg && c_byp_addr_reg == s1_ci_reg) ? c_byp_data_reg : c_rdata;
        b_cur = (b_byp_valid_reg && b_byp_addr_reg == s1_bi_reg) ? b_byp_data_reg : b_rdata;
        g_cur = (g_byp_valid_reg && g_byp_addr_reg == s1_gi_reg) ? g_byp_data_reg : g_rdata;
    end

    hbp_update u_update (
        .taken       (s1_taken_reg),
        .bimodal_ctr (b_cur),
        .gshare_ctr  (g_cur),
        .chooser_ctr (c_cur),
        .upd         (upd)
    );

    always_comb
    begin
        if (clearing_reg)
        begin
            c_we    = 1'b1;
            c_waddr = clr_cnt_reg[CI-1:0];
            c_wdata = hbp_pkg::CHOOSER_RESET;
            b_we    = 1'b1;
            b_waddr = clr_cnt_reg[BI-1:0];
            b_wdata = hbp_pkg::CTR3_RESET;
            g_we    = 1'b1;
            g_waddr = clr_cnt_reg[GI-1:0];
            g_wdata = hbp_pkg::CTR3_RESET;
        end
        else
        begin
            c_we    = s1_valid_reg;
            c_waddr = s1_ci_reg;
            c_wdata = upd.chooser_ctr;
            b_we    = s1_valid_reg && upd.bimodal_we;
            b_waddr = s1_bi_reg;
            b_wdata = upd.bimodal_ctr;
            g_we    = s1_valid_reg && upd.gshare_we;
            g_waddr = s1_gi_reg;
            g_wdata = upd.gshare_ctr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_byp_valid_reg <= 1'b0;
            b_byp_valid_reg <= 1'b0;
            g_byp_valid_reg <= 1'b0;
        end
        else
        begin
            c_byp_valid_reg <= c_we;
            b_byp_valid_reg <= b_we;
            g_byp_valid_reg <= g_we;
        end
    end

    always_ff @(posedge clk)
    begin
        c_byp_addr_reg <= c_waddr;
        c_byp_data_reg <= c_wdata;
        b_byp_addr_reg <= b_waddr;
        b_byp_data_reg <= b_wdata;
        g_byp_addr_reg <= g_waddr;
        g_byp_data_reg <= g_wdata;
    end

    hbp_ram #(
        .WIDTH (2),
        .DEPTH (1 << CI)
    ) u_chooser_ram (
        .clk     (clk),
        .wr_en   (c_we),
        .wr_addr (c_waddr),
        .wr_data (c_wdata),
        .rd_addr (ci_in),
        .rd_data (c_rdata)
    );

    hbp_ram #(
        .WIDTH (3),
        .DEPTH (1 << BI)
    ) u_bimodal_ram (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (b_wdata),
        .rd_addr (bi_in),
        .rd_data (b_rdata)
    );

    hbp_ram #(
        .WIDTH (3),
        .DEPTH (1 << GI)
    ) u_gshare_ram (
        .clk     (clk),
        .wr_en   (g_we),
        .wr_addr (g_waddr),
        .wr_data (g_wdata),
        .rd_addr (gi_in),
        .rd_data (g_rdata)
    );

    always_comb
    begin
        s1_result.predicted_taken = upd.predicted_taken;
        s1_result.mispredicted    = upd.mispredicted;
        s1_result.chose_gshare    = upd.chose_gshare;
    end

    hbp_out_queue u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (s1_valid_reg),
        .push_data    (s1_result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .count        (q_count)
    );

    `ASSERT_CLK_ALWAYS(a_no_accept_in_clear, clearing_reg |-> !branch_ready, "branch in clear")
    `ASSERT_CLK(a_accept_reaches_update, accept |=> s1_valid_reg, "branch lost")
    `ASSERT_CLK(a_queue_no_overflow, (s1_valid_reg && q_count == 2'd3) |-> (result_valid && result_ready), "queue overflow")
    `ASSERT_CLK(a_one_table_trained, (s1_valid_reg && !clearing_reg) |-> (b_we != g_we), "training not exclusive")

endmodule

`default_nettype wire

/* tb/tb_hybrid_branch_predictor.sv */
// ----------------------------------------------------------------------------
// tb_hybrid_branch_predictor
// self-checking testbench for the tournament branch predictor
// ----------------------------------------------------------------------------
// A directed table of resolved branches runs first. It covers the pc extremes,
// byte offsets that alias one word, the chooser swinging over to gshare and
// counters saturating at both ends. Random traffic follows: mostly a small set
// of hot branch sites with biased, looping or correlated outcomes, and a share
// of fully random branches. A local model of the three tables and the global
// history predicts every result. Both handshakes idle at random, and the
// result side holds off for one long stretch to fill the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hybrid_branch_predictor;

    localparam int CHOOSER_BITS = 10;
    localparam int BIMODAL_BITS = 12;
    localparam int GSHARE_BITS  = 12;
    localparam int HIST_BITS    = 8;

    localparam int NUM_DIRECTED = 25;
    localparam int NUM_RANDOM   = 525;
    localparam int NUM_SITES    = 16;
    localparam int MAX_GAP      = 9;
    localparam int LONG_HOLD    = 60;
    localparam int BURST_LEN    = 30;
    localparam int PAUSE_AT     = 200;
    localparam int BURST_AT     = 320;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    // fresh entries: bimodal at its reset value predicts taken
    localparam hbp_pkg::result_t FRESH_HIT  = '{predicted_taken: 1'b1, mispredicted: 1'b0,
                                                chose_gshare: 1'b0};
    localparam hbp_pkg::result_t FRESH_MISS = '{predicted_taken: 1'b1, mispredicted: 1'b1,
                                                chose_gshare: 1'b0};
    localparam hbp_pkg::result_t NO_CHECK   = '0;

    typedef struct packed {
        logic [31:0]      pc;
        logic             taken;
        logic             known;
        hbp_pkg::result_t want;
    } branch_row_t;

    typedef struct packed {
        logic [31:0]      pc;
        hbp_pkg::result_t res;
    } due_result_t;

    typedef enum logic [1:0] {
        SITE_MOSTLY_TAKEN,
        SITE_MOSTLY_NOT,
        SITE_LOOP,
        SITE_FOLLOW_LAST
    } site_kind_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             branch_valid = 1'b0;
    logic             branch_ready;
    hbp_pkg::branch_t branch       = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    hbp_pkg::result_t result;

    // local copy of the predictor state
    hbp_pkg::ctr2_t       chooser_tbl [2**CHOOSER_BITS];
    hbp_pkg::ctr3_t       bimodal_tbl [2**BIMODAL_BITS];
    hbp_pkg::ctr3_t       gshare_tbl  [2**GSHARE_BITS];
    logic [HIST_BITS-1:0] global_hist;

    due_result_t due_results [$];
    int          mismatch_count = 0;
    bit          hold_request   = 1'b0;
    bit          sender_calm    = 1'b0;

    // hot branch sites for the random part
    logic [31:0] site_pc    [NUM_SITES];
    site_kind_t  site_kind  [NUM_SITES];
    int          site_trip  [NUM_SITES];
    int          site_count [NUM_SITES];
    logic        last_outcome = 1'b0;

    branch_row_t directed_rows [NUM_DIRECTED] = '{
        '{32'h0000_0000, 1'b1, 1'b1, FRESH_HIT},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, FRESH_MISS},
        '{32'h0000_0AA8, 1'b0, 1'b1, FRESH_MISS},
        // byte offset bits are dropped: same word as the first row
        '{32'h0000_0003, 1'b0, 1'b0, NO_CHECK},
        '{32'h8000_0000, 1'b1, 1'b0, NO_CHECK},
        '{32'h7FFF_FFFC, 1'b1, 1'b0, NO_CHECK},
        '{32'h5555_5555, 1'b0, 1'b0, NO_CHECK},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, NO_CHECK},
        // bimodal goes wrong alone, chooser moves over to gshare
        '{32'h0000_0400, 1'b0, 1'b0, NO_CHECK},
        '{32'h0000_0400, 1'b1, 1'b0, NO_CHECK},
        '{32'h0000_0400, 1'b0, 1'b0, NO_CHECK},
        '{32'h0000_0400, 1'b0, 1'b0, NO_CHECK},
        '{32'h0000_0400, 1'b1, 1'b0, NO_CHECK},
        '{32'h0000_0400, 1'b1, 1'b0, NO_CHECK},
        '{32'h0000_0400, 1'b1, 1'b0, NO_CHECK},
        // bimodal counter down to zero, chooser down to zero
        '{32'h0000_0800, 1'b0, 1'b0, NO_CHECK},
        '{32'h0000_0800, 1'b0, 1'b0, NO_CHECK},
        '{32'h0000_0800, 1'b0, 1'b0, NO_CHECK},
        '{32'h0000_0800, 1'b0, 1'b0, NO_CHECK},
        '{32'h0000_0800, 1'b0, 1'b0, NO_CHECK},
        // bimodal counter up to seven and held there
        '{32'hFFFF_FFF0, 1'b1, 1'b0, NO_CHECK},
        '{32'hFFFF_FFF0, 1'b1, 1'b0, NO_CHECK},
        '{32'hFFFF_FFF0, 1'b1, 1'b0, NO_CHECK},
        '{32'hFFFF_FFF0, 1'b1, 1'b0, NO_CHECK},
        '{32'hFFFF_FFF0, 1'b1, 1'b0, NO_CHECK}
    };

    hybrid_branch_predictor #(
        .CHOOSER_INDEX_BITS (CHOOSER_BITS),
        .BIMODAL_INDEX_BITS (BIMODAL_BITS),
        .GSHARE_INDEX_BITS  (GSHARE_BITS),
        .HISTORY_BITS       (HIST_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .branch_valid (branch_valid),
        .branch_ready (branch_ready),
        .branch       (branch),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic hbp_pkg::ctr3_t saturate_toward(input hbp_pkg::ctr3_t c,
                                                       input logic up);
        if (up)
            return (c == hbp_pkg::CTR3_MAX) ? c : c + 3'd1;
        return (c == 3'd0) ? c : c - 3'd1;
    endfunction

    // forms both predictions, then trains the chosen table, the chooser and the history
    function automatic hbp_pkg::result_t predict_and_train(input hbp_pkg::branch_t b);
        logic [hbp_pkg::WORD_PC_BITS-1:0] wpc;
        logic [CHOOSER_BITS-1:0]          ci;
        logic [BIMODAL_BITS-1:0]          bi;
        logic [GSHARE_BITS-1:0]           gi;
        logic                             bim_taken;
        logic                             gsh_taken;
        logic                             use_gshare;
        hbp_pkg::ctr2_t                   ch;
        hbp_pkg::result_t                 r;
        wpc        = b.branch_pc[31:2];
        ci         = wpc[CHOOSER_BITS-1:0];
        bi         = wpc[BIMODAL_BITS-1:0];
        gi         = wpc[GSHARE_BITS-1:0] ^ GSHARE_BITS'(global_hist);
        bim_taken  = bimodal_tbl[bi] >= hbp_pkg::CTR3_TAKEN_MIN;
        gsh_taken  = gshare_tbl[gi] >= hbp_pkg::CTR3_TAKEN_MIN;
        ch         = chooser_tbl[ci];
        use_gshare = ch >= hbp_pkg::CHOOSER_G_MIN;

        r.predicted_taken = use_gshare ? gsh_taken : bim_taken;
        r.mispredicted    = r.predicted_taken != b.taken;
        r.chose_gshare    = use_gshare;

        if (use_gshare)
            gshare_tbl[gi] = saturate_toward(gshare_tbl[gi], b.taken);
        else
            bimodal_tbl[bi] = saturate_toward(bimodal_tbl[bi], b.taken);

        global_hist = {b.taken, global_hist[HIST_BITS-1:1]};

        if (bim_taken == b.taken && gsh_taken != b.taken)
        begin
            if (ch != 2'd0)
                ch = ch - 2'd1;
        end
        else if (bim_taken != b.taken && gsh_taken == b.taken)
        begin
            if (ch != hbp_pkg::CHOOSER_MAX)
                ch = ch + 2'd1;
        end
        chooser_tbl[ci] = ch;
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_branch(input hbp_pkg::branch_t b, input int gap, input logic known,
                               input hbp_pkg::result_t want);
        due_result_t      due;
        hbp_pkg::result_t predicted;
        if (gap > 0)
        begin
            branch_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        branch_valid <= 1'b1;
        branch       <= b;
        @(posedge clk);
        while (!branch_ready)
            @(posedge clk);
        predicted = predict_and_train(b);
        due.pc    = b.branch_pc;
        due.res   = known ? want : predicted;
        due_results = {due_results, due};
        @(negedge clk);
    endtask

    function automatic int draw_gap();
        return sender_calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // result side: random stalls, one long hold on request
    initial
    begin
        int          stall;
        int          received;
        bit          calm;
        due_result_t due;
        received = 0;
        calm     = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (received % 32 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            received++;
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result transaction: taken=%0b miss=%0b gshare=%0b",
                             result.predicted_taken, result.mispredicted,
                             result.chose_gshare);
            end
            else
            begin
                due = due_results.pop_front();
                if (result.predicted_taken !== due.res.predicted_taken ||
                    result.mispredicted !== due.res.mispredicted ||
                    result.chose_gshare !== due.res.chose_gshare)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch pc=%h: expected taken=%0b miss=%0b gshare=%0b, %s",
                                 due.pc, due.res.predicted_taken, due.res.mispredicted,
                                 due.res.chose_gshare,
                                 $sformatf("got taken=%0b miss=%0b gshare=%0b",
                                           result.predicted_taken, result.mispredicted,
                                           result.chose_gshare));
                end
            end
            @(negedge clk);
        end
    end

    // run limit, sized for the clearing pass plus worst-case idling
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int               k;
        int               s;
        int               gap;
        hbp_pkg::branch_t b;

        foreach (chooser_tbl[i])
            chooser_tbl[i] = hbp_pkg::CHOOSER_RESET;
        foreach (bimodal_tbl[i])
            bimodal_tbl[i] = hbp_pkg::CTR3_RESET;
        foreach (gshare_tbl[i])
            gshare_tbl[i] = hbp_pkg::CTR3_RESET;
        global_hist = '0;

        for (s = 0; s < NUM_SITES; s++)
        begin
            site_pc[s]    = $urandom;
            site_kind[s]  = site_kind_t'($urandom_range(0, 3));
            site_trip[s]  = $urandom_range(2, 6);
            site_count[s] = 0;
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < NUM_DIRECTED; k++)
        begin
            b.branch_pc = directed_rows[k].pc;
            b.taken     = directed_rows[k].taken;
            send_branch(b, $urandom_range(0, MAX_GAP), directed_rows[k].known,
                        directed_rows[k].want);
        end

        for (k = 0; k < NUM_RANDOM; k++)
        begin
            if (k % 32 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            gap = draw_gap();

            if (k == PAUSE_AT)
            begin
                // let the block run dry before going on
                branch_valid <= 1'b0;
                @(negedge clk);
                while (due_results.size() != 0)
                    @(negedge clk);
            end
            if (k == BURST_AT)
                hold_request = 1'b1;
            if (k >= BURST_AT && k < BURST_AT + BURST_LEN)
                gap = 0;

            if ($urandom_range(0, 3) == 0)
            begin
                b.branch_pc = $urandom;
                b.taken     = 1'($urandom_range(0, 1));
            end
            else
            begin
                s = $urandom_range(0, NUM_SITES - 1);
                b.branch_pc = site_pc[s];
                case (site_kind[s])
                    SITE_MOSTLY_TAKEN: b.taken = ($urandom_range(0, 9) != 0);
                    SITE_MOSTLY_NOT:   b.taken = ($urandom_range(0, 9) == 0);
                    SITE_LOOP:
                    begin
                        site_count[s]++;
                        b.taken = (site_count[s] % site_trip[s]) != 0;
                    end
                    default:           b.taken = last_outcome;
                endcase
            end
            last_outcome = b.taken;
            send_branch(b, gap, 1'b0, NO_CHECK);
        end
        branch_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
